### rtl/sots_pkg.sv
// ----------------------------------------------------------------------------
// sots_pkg
// Shared types, codes and sizes for the sorted offset table search block.
// ----------------------------------------------------------------------------
package sots_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
   localparam int OFFSET_W    = 32;
   localparam int INDEX_W     = 10;

   typedef enum logic [1:0] {
      CMD_APPEND = 2'd0,
      CMD_GET    = 2'd1,
      CMD_FIND   = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_REFUSED  = 2'd1,
      ST_RANGE    = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_GET_WAIT,
      S_FIND_RUN,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]          command;
      logic [OFFSET_W-1:0] operand;
   } req_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] offset_out;
      logic [INDEX_W-1:0]  index_out;
      logic [1:0]          status;
   } rsp_type;

   // One bisection step: new bounds, value at the low bound, next probe
   typedef struct packed {
      logic [ADDR_W-1:0]   lo;
      logic [COUNT_W-1:0]  hi;
      logic [OFFSET_W-1:0] lo_val;
      logic [ADDR_W-1:0]   mid;
      logic                more;
   } step_type;

endpackage

### rtl/sots_step.sv
// ----------------------------------------------------------------------------
// sots_step
// Bisection unit: one compare, bound update and next probe address.
// ----------------------------------------------------------------------------
module sots_step (
   input  logic [sots_pkg::ADDR_W-1:0]   lo,
   input  logic [sots_pkg::COUNT_W-1:0]  hi,
   input  logic [sots_pkg::ADDR_W-1:0]   mid,
   input  logic [sots_pkg::OFFSET_W-1:0] lo_val,
   input  logic [sots_pkg::OFFSET_W-1:0] mid_val,
   input  logic [sots_pkg::OFFSET_W-1:0] query,
   output sots_pkg::step_type            step
);
   import sots_pkg::*;

   logic               le;
   logic [COUNT_W-1:0] lo_ext;
   logic [COUNT_W-1:0] span;
   logic [COUNT_W-1:0] probe;

   always_comb begin
      le          = (mid_val <= query);
      step.lo     = le ? mid : lo;
      step.lo_val = le ? mid_val : lo_val;
      step.hi     = le ? hi : COUNT_W'(mid);
      lo_ext      = COUNT_W'(step.lo);
      span        = step.hi - lo_ext;
      probe       = lo_ext + (span >> 1);
      step.mid    = probe[ADDR_W-1:0];
      // continue while at least two candidates remain
      step.more   = (lo_ext + COUNT_W'(1)) < step.hi;
   end

endmodule

### rtl/sorted_offset_table_search.sv
// ----------------------------------------------------------------------------
// sorted_offset_table_search
// Table of strictly increasing offsets with append, get and binary find.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req_payload) carries one command per
//   transaction: append an offset, get the offset at an index, or find the
//   greatest index whose offset is at or below a query. rsp channel
//   (rsp_valid/rsp_ready/rsp_payload) returns exactly one result per command.
//   The block handles one transaction at a time; req_ready is high only when
//   the sequencer is idle.
// Flow from accept to rsp_valid: append, unused command, out-of-range get,
//   rejected find and a find over one entry go straight to the done state;
//   a valid get passes through one registered memory read first; a longer
//   find runs its bisection probes in the search state first. The done
//   state moves the result to the output register, and req_ready returns
//   in that same cycle. A find is bounded by the single memory read port:
//   one bisection probe per cycle through the step unit.
// Reset: synchronous, active high; empties the table (entry count zero) and
//   drops any pending result. No clearing pass runs over the memory.
// Stall: a finished result holds in the output register until rsp_ready;
//   the next transaction is accepted meanwhile, and its own result waits in
//   the sequencer until the output register frees up.
// ----------------------------------------------------------------------------
module sorted_offset_table_search (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sots_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sots_pkg::rsp_type rsp_payload
);
   import sots_pkg::*;

   // offset memory, one write and one registered read port
   logic [OFFSET_W-1:0] mem [TABLE_DEPTH];
   logic [OFFSET_W-1:0] rd_data_ff;
   logic                rd_en;
   logic [ADDR_W-1:0]   rd_addr;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;

   state_type           state_ff, state_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [OFFSET_W-1:0] first_ff, first_in;
   logic [OFFSET_W-1:0] last_ff, last_in;
   logic [OFFSET_W-1:0] query_ff, query_in;
   logic [ADDR_W-1:0]   lo_ff, lo_in;
   logic [COUNT_W-1:0]  hi_ff, hi_in;
   logic [ADDR_W-1:0]   mid_ff, mid_in;
   logic [OFFSET_W-1:0] lo_val_ff, lo_val_in;
   rsp_type             res_ff, res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   step_type            step;
   logic                accept;
   logic [COUNT_W-1:0]  half;

   assign req_ready   = (state_ff == S_IDLE);
   assign accept      = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign wr_addr     = count_ff[ADDR_W-1:0];
   assign half        = count_ff >> 1;

   sots_step u_step (
      .lo      (lo_ff),
      .hi      (hi_ff),
      .mid     (mid_ff),
      .lo_val  (lo_val_ff),
      .mid_val (rd_data_ff),
      .query   (query_ff),
      .step    (step)
   );

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_payload.operand;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      query_in     = query_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      lo_val_in    = lo_val_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rd_en        = 1'b0;
      rd_addr      = mid_ff;
      wr_en        = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_in   = '0;
               query_in = req_payload.operand;
               state_in = S_DONE;
               unique case (req_payload.command)
                  CMD_APPEND: begin
                     if (count_ff == COUNT_W'(TABLE_DEPTH)) begin
                        res_in.status = ST_REFUSED;
                     end else if (count_ff != '0 && last_ff >= req_payload.operand) begin
                        res_in.status = ST_REFUSED;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + COUNT_W'(1);
                        last_in  = req_payload.operand;
                        if (count_ff == '0) begin
                           first_in = req_payload.operand;
                        end
                     end
                  end
                  CMD_GET: begin
                     if (req_payload.operand < OFFSET_W'(count_ff)) begin
                        rd_en    = 1'b1;
                        rd_addr  = req_payload.operand[ADDR_W-1:0];
                        state_in = S_GET_WAIT;
                     end else begin
                        res_in.status = ST_RANGE;
                     end
                  end
                  CMD_FIND: begin
                     // drop out early on empty table or query outside the span
                     if (count_ff == '0 || req_payload.operand < first_ff ||
                         req_payload.operand > last_ff) begin
                        res_in.status = ST_NOTFOUND;
                     end else if (count_ff == COUNT_W'(1)) begin
                        res_in.status = (first_ff == req_payload.operand) ?
                                        ST_OK : ST_NOTFOUND;
                     end else begin
                        lo_in     = '0;
                        hi_in     = count_ff;
                        lo_val_in = first_ff;
                        mid_in    = half[ADDR_W-1:0];
                        rd_en     = 1'b1;
                        rd_addr   = half[ADDR_W-1:0];
                        state_in  = S_FIND_RUN;
                     end
                  end
                  CMD_NONE: begin
                     res_in = '0;
                  end
                  default: begin
                     res_in = '0;
                  end
               endcase
            end
         end
         S_GET_WAIT: begin
            res_in.offset_out = rd_data_ff;
            res_in.status     = ST_OK;
            state_in          = S_DONE;
         end
         S_FIND_RUN: begin
            lo_in     = step.lo;
            hi_in     = step.hi;
            lo_val_in = step.lo_val;
            mid_in    = step.mid;
            if (step.more) begin
               rd_en   = 1'b1;
               rd_addr = step.mid;
            end else begin
               res_in.index_out = INDEX_W'(step.lo);
               res_in.status    = (step.lo_val == query_ff) ? ST_OK : ST_NOTFOUND;
               state_in         = S_DONE;
            end
         end
         S_DONE: begin
            // hold the result until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff  <= first_in;
      last_ff   <= last_in;
      query_ff  <= query_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      lo_val_ff <= lo_val_in;
      res_ff    <= res_in;
      rsp_ff    <= rsp_in;
   end

endmodule

### rtl/sots_checker.sv
// ----------------------------------------------------------------------------
// sots_checker
// Port-level checks for the sorted offset table search block.
// ----------------------------------------------------------------------------
module sots_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input sots_pkg::rsp_type rsp_payload
);
   import sots_pkg::*;

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed or dropped");

   // one transaction at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second transaction accepted while busy");

   // only a find reports a nonzero index
   a_index_from_find: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.index_out != '0 |->
         rsp_payload.status == ST_OK || rsp_payload.status == ST_NOTFOUND)
      else $error("index reported with wrong status");

   // only a successful get reports an offset
   a_offset_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.offset_out != '0 |->
         rsp_payload.status == ST_OK && rsp_payload.index_out == '0)
      else $error("offset reported with error status or index");

endmodule

bind sorted_offset_table_search sots_checker u_sots_checker (.*);

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sorted offset table search block. Commands go
// in through the req channel, and a local table model predicts one result
// per accepted transaction. Each rsp transaction is compared field by field
// against the oldest prediction. Directed edge cases come first. Random
// traffic follows, growing the table until it is full, with random idle
// bursts on both channels and long holds on the result side.
// ----------------------------------------------------------------------------
module testbench;
   import sots_pkg::*;

   // Highest offset the bench ever appends; one below the top of the range,
   // so that a full table can still be hit with an increasing offset.
   localparam logic [31:0] LAST_OFFSET  = 32'hFFFF_FFFE;
   localparam int          SETTLE_CYCLES = 16;   // about one full-depth find
   localparam int          DRAIN_LIMIT   = 5000;
   localparam int          REPORT_LIMIT  = 10;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   // Local copy of the table, updated as each transaction is accepted
   logic [31:0] offset_table [TABLE_DEPTH];
   int unsigned stored_count = 0;

   rsp_type     expected_q [$];
   int          error_count = 0;
   bit          idle_on = 1'b1;
   int          ready_hold_cycles = 0;

   sorted_offset_table_search i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #10ms;
      $display("TEST FAILED");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Prediction
   // -------------------------------------------------------------------------

   // Greatest index whose offset is at or below the query; exact hit gives ok
   function automatic rsp_type search_offset(input logic [31:0] query);
      rsp_type     rs;
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      rs = '0;
      if (stored_count == 0 || query < offset_table[0] ||
          query > offset_table[stored_count-1]) begin
         rs.status = ST_NOTFOUND;
      end else begin
         lo = 0;
         hi = stored_count;
         while (lo + 1 < hi) begin
            mid = lo + (hi - lo) / 2;
            if (offset_table[mid] <= query)
               lo = mid;
            else
               hi = mid;
         end
         rs.index_out = lo[INDEX_W-1:0];
         rs.status    = (offset_table[lo] == query) ? ST_OK : ST_NOTFOUND;
      end
      return rs;
   endfunction

   // Apply one accepted command to the local table and return its result
   function automatic rsp_type apply_command(input req_type item);
      rsp_type rs;
      rs = '0;
      case (cmd_type'(item.command))
         CMD_APPEND: begin
            if (stored_count >= TABLE_DEPTH)
               rs.status = ST_REFUSED;
            else if (stored_count > 0 && offset_table[stored_count-1] >= item.operand)
               rs.status = ST_REFUSED;
            else begin
               offset_table[stored_count] = item.operand;
               stored_count++;
            end
         end
         CMD_GET: begin
            if (item.operand < stored_count)
               rs.offset_out = offset_table[item.operand[ADDR_W-1:0]];
            else
               rs.status = ST_RANGE;
         end
         CMD_FIND: rs = search_offset(item.operand);
         default: ;   // unused command: all fields zero
      endcase
      return rs;
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------

   function automatic req_type make_item(input cmd_type cmd, input logic [31:0] operand);
      req_type item;
      item.command = cmd;
      item.operand = operand;
      return item;
   endfunction

   // Next increasing offset. Each step takes at most an even share of the
   // room left, so the table can always be filled up to LAST_OFFSET.
   function automatic logic [31:0] next_offset(input bit small_step);
      longint unsigned last_val;
      longint unsigned room;
      longint unsigned span;
      int unsigned     slots_left;
      slots_left = TABLE_DEPTH - stored_count;
      last_val   = (stored_count > 0) ? offset_table[stored_count-1] : 0;
      room       = LAST_OFFSET - last_val;
      span       = room / slots_left;
      if (span == 0)
         span = 1;
      if (small_step && span > 4)
         span = 4;
      if (slots_left == 1)
         return LAST_OFFSET;
      return 32'(last_val + $urandom_range(1, span));
   endfunction

   // Mostly well-formed commands against the current table, some noise
   function automatic req_type make_random_item();
      req_type     item;
      int unsigned pick;
      int unsigned slot;
      logic [31:0] last_val;
      logic [31:0] spacing;
      pick         = $urandom_range(0, 99);
      item.command = CMD_NONE;
      item.operand = $urandom();
      last_val     = (stored_count > 0) ? offset_table[stored_count-1] : '0;
      slot         = (stored_count > 0) ? $urandom_range(0, stored_count - 1) : 0;
      if (pick < 35) begin
         item.command = CMD_APPEND;
         if (stored_count == 0 ||
             (stored_count < TABLE_DEPTH && $urandom_range(0, 9) < 8))
            item.operand = next_offset($urandom_range(0, 3) == 0);
         else if ($urandom_range(0, 1) == 0)
            item.operand = last_val;
         else
            item.operand = $urandom_range(0, last_val);
      end else if (pick < 65) begin
         item.command = CMD_GET;
         pick = $urandom_range(0, 19);
         if (stored_count > 0 && pick < 14)
            item.operand = slot;
         else if (pick < 17)
            item.operand = stored_count;
      end else if (pick < 95) begin
         item.command = CMD_FIND;
         pick = $urandom_range(0, 19);
         if (stored_count > 0) begin
            if (pick < 10) begin
               item.operand = offset_table[slot];
            end else if (pick < 15) begin
               // land strictly between two neighbors where there is room
               spacing = (slot + 1 < stored_count) ?
                         offset_table[slot+1] - offset_table[slot] : 32'd2;
               item.operand = offset_table[slot] +
                              ((spacing > 1) ? $urandom_range(1, spacing - 1) : 1);
            end else if (pick < 17 && offset_table[0] > 0) begin
               item.operand = $urandom_range(0, offset_table[0] - 1);
            end
         end
      end
      return item;
   endfunction

   // -------------------------------------------------------------------------
   // Request driver: offer one transaction and hold it until accepted
   // -------------------------------------------------------------------------
   task automatic send_item(input req_type item);
      req_type noise;
      int      gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap           = $urandom_range(1, 19);
         noise.command = $urandom_range(0, 3);
         noise.operand = $urandom();
         req_valid   <= 1'b0;
         req_payload <= noise;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // Predict at acceptance, so the next item sees the updated table
      expected_q = {expected_q, apply_command(item)};
   endtask

   // Drop valid and hold until every predicted result has come back or the drain limit runs out
   task automatic wait_results_drained();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Result side: ready with random stalls, and long holds on request
   // -------------------------------------------------------------------------
   initial begin : rsp_ready_driver
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (ready_hold_cycles > 0) begin
            ready_hold_cycles--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 19) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Compare each rsp transaction with the oldest prediction
   always @(posedge clock) begin : result_checker
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("%0t: result with none expected: offset %h index %0d status %0d",
                        $realtime, rsp_payload.offset_out, rsp_payload.index_out,
                        rsp_payload.status);
         end else begin
            want = expected_q.pop_front();
            if (rsp_payload.offset_out !== want.offset_out ||
                rsp_payload.index_out  !== want.index_out  ||
                rsp_payload.status     !== want.status) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display({"%0t: mismatch: expected offset %h index %0d status %0d, ",
                            "got offset %h index %0d status %0d"}, $realtime,
                           want.offset_out, want.index_out, want.status,
                           rsp_payload.offset_out, rsp_payload.index_out,
                           rsp_payload.status);
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Find, get and unused commands against a table fresh out of reset
   task automatic test_empty_table();
      send_item(make_item(CMD_FIND, 32'd0));
      send_item(make_item(CMD_FIND, 32'hFFFF_FFFF));
      send_item(make_item(CMD_GET, 32'd0));
      send_item(make_item(CMD_GET, 32'hFFFF_FFFF));
      send_item(make_item(CMD_NONE, 32'hFFFF_FFFF));
   endtask

   // Appends that grow the table, and ones refused as not increasing
   task automatic test_append_rules();
      send_item(make_item(CMD_APPEND, 32'd16));
      send_item(make_item(CMD_APPEND, 32'd0));      // below last
      send_item(make_item(CMD_APPEND, 32'd16));     // equal to last
      send_item(make_item(CMD_APPEND, 32'd17));     // adjacent
      send_item(make_item(CMD_APPEND, 32'd40));
      send_item(make_item(CMD_APPEND, 32'd39));     // below last
      send_item(make_item(CMD_APPEND, 32'h0000_0100));
   endtask

   task automatic test_get_index();
      send_item(make_item(CMD_GET, 32'd0));
      send_item(make_item(CMD_GET, 32'd3));
      send_item(make_item(CMD_GET, 32'd4));         // first index past the end
      send_item(make_item(CMD_GET, 32'h8000_0000));
   endtask

   // Exact hits, a miss between entries, and queries outside the table
   task automatic test_find_offset();
      send_item(make_item(CMD_FIND, 32'd16));
      send_item(make_item(CMD_FIND, 32'd17));
      send_item(make_item(CMD_FIND, 32'd30));
      send_item(make_item(CMD_FIND, 32'h0000_0100));
      send_item(make_item(CMD_FIND, 32'd3));
      send_item(make_item(CMD_FIND, 32'h0000_0101));
      send_item(make_item(CMD_NONE, 32'd0));
   endtask

   task automatic test_random_mix(input int count);
      repeat (count) send_item(make_random_item());
   endtask

   // Hold the result side for a long stretch while the sender keeps offering,
   // so the block fills up and stops taking requests
   task automatic test_receiver_hold();
      bit saved_idle;
      saved_idle        = idle_on;
      idle_on           = 1'b0;
      ready_hold_cycles = 400;
      repeat (12) send_item(make_random_item());
      idle_on = saved_idle;
   endtask

   // Pause the sender until nothing is outstanding, then resume
   task automatic test_sender_pause();
      wait_results_drained();
      repeat (40) send_item(make_random_item());
   endtask

   task automatic test_fill_table();
      while (stored_count < TABLE_DEPTH)
         send_item(make_item(CMD_APPEND, next_offset(1'b0)));
   endtask

   // Edges of a full table: refused append, last index, deepest searches
   task automatic test_full_table();
      send_item(make_item(CMD_APPEND, 32'hFFFF_FFFF));
      send_item(make_item(CMD_APPEND, 32'd0));
      send_item(make_item(CMD_GET, 32'(TABLE_DEPTH - 1)));
      send_item(make_item(CMD_GET, 32'(TABLE_DEPTH)));
      send_item(make_item(CMD_GET, 32'hFFFF_FFFF));
      send_item(make_item(CMD_FIND, LAST_OFFSET));
      send_item(make_item(CMD_FIND, 32'hFFFF_FFFF));
      send_item(make_item(CMD_FIND, offset_table[0]));
      send_item(make_item(CMD_FIND, 32'd0));
      send_item(make_item(CMD_FIND, offset_table[TABLE_DEPTH/2] + 1));
   endtask

   // -------------------------------------------------------------------------
   // Sequence
   // -------------------------------------------------------------------------
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_append_rules();
      test_get_index();
      test_find_offset();

      test_random_mix(200);
      test_receiver_hold();
      test_random_mix(150);
      test_sender_pause();

      // Run a stretch with both sides always ready
      idle_on = 1'b0;
      test_random_mix(60);
      idle_on = 1'b1;

      test_fill_table();
      test_full_table();

      // Finish with no idling at all
      idle_on = 1'b0;
      test_random_mix(100);

      wait_results_drained();
      if (expected_q.size() != 0)
         $display("%0d expected results never arrived", expected_q.size());
      if (error_count == 0 && expected_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
